/* src/uripsp_pkg.sv */
package uripsp_pkg;

   localparam int DEPTH_BITS = 8;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [1:0] KIND_NAME  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_CHAR = 2'd1;
   localparam logic [1:0] OP_SEP  = 2'd2;

   localparam logic [1:0] ESC_IDLE   = 2'd0;
   localparam logic [1:0] ESC_FIRST  = 2'd1;
   localparam logic [1:0] ESC_SECOND = 2'd2;

   localparam int OPQ_DEPTH     = 4;
   localparam int OPQ_PTR_BITS  = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_BITS  = $clog2(OPQ_DEPTH + 1);
   localparam int RSPQ_DEPTH    = 4;
   localparam int RSPQ_PTR_BITS = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_BITS = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic [1:0] code;
      logic [7:0] ch;
      logic       last;
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic       eou;
   } rsp_type;

   typedef struct packed {
      logic [1:0] n;
      rsp_type    r0;
      rsp_type    r1;
   } rsp_wr_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

/* src/uri_path_segment_parser_core.sv */
// channel   ports                                        handshake
// request   req_uri_byte, req_last_byte                  push / full
// response  rsp_token_kind, rsp_char_out, rsp_end_of_uri  empty / pop
//
// Takes one byte per cycle; full rises only when the 4-entry op queue is full.
// Each byte yields 0 to 2 responses; the response side delivers one per cycle
// while pop is high and the result queue is not empty.
// A pushed byte is registered in the op queue, then its responses in the result queue.
// The back end processes an op only when the result queue has room for two.
// Synchronous reset clears all parse state and both queues.
module uri_path_segment_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_uri_byte,
   input  logic       req_last_byte,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_token_kind,
   output logic [7:0] rsp_char_out,
   output logic       rsp_end_of_uri
);

   uripsp_pkg::op_type       op_w, op_r;
   uripsp_pkg::rsp_wr_type   wr;
   uripsp_pkg::rsp_type      rsp;
   logic                     accept, op_push, op_valid, op_pop, room2;

   assign accept = push && !full;

   uripsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .uri_byte  (req_uri_byte),
      .last_byte (req_last_byte),
      .op_push   (op_push),
      .op        (op_w)
   );

   uripsp_op_fifo u_op_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_i (op_push),
      .wdata  (op_w),
      .full   (full),
      .pop_i  (op_pop),
      .valid  (op_valid),
      .rdata  (op_r)
   );

   uripsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op       (op_r),
      .room2    (room2),
      .op_pop   (op_pop),
      .wr       (wr)
   );

   uripsp_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .room2 (room2),
      .pop_i (pop),
      .empty (empty),
      .rdata (rsp)
   );

   assign rsp_token_kind = rsp.kind;
   assign rsp_char_out   = rsp.ch;
   assign rsp_end_of_uri = rsp.eou;

endmodule

/* src/uripsp_front.sv */
module uripsp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           uri_byte,
   input  logic                 last_byte,
   output logic                 op_push,
   output uripsp_pkg::op_type   op
);

   logic [1:0] esc_ff, esc_in;
   logic [3:0] hi_ff, hi_in;
   logic       query_ff, query_in;
   logic [3:0] hex;

   assign hex = uripsp_pkg::hex_value(uri_byte);

   always_comb begin
      esc_in   = esc_ff;
      hi_in    = hi_ff;
      query_in = query_ff;
      op.code  = uripsp_pkg::OP_NONE;
      op.ch    = uri_byte;
      op.last  = last_byte;
      if (!query_ff) begin
         unique case (esc_ff)
            uripsp_pkg::ESC_FIRST: begin
               if (last_byte) begin
                  esc_in  = uripsp_pkg::ESC_IDLE;
                  op.code = uripsp_pkg::OP_CHAR;
                  op.ch   = {hex, 4'h0};
               end else begin
                  hi_in  = hex;
                  esc_in = uripsp_pkg::ESC_SECOND;
               end
            end
            uripsp_pkg::ESC_SECOND: begin
               esc_in  = uripsp_pkg::ESC_IDLE;
               op.code = uripsp_pkg::OP_CHAR;
               op.ch   = {hi_ff, hex};
            end
            default: begin
               priority if (uri_byte == uripsp_pkg::CH_QUEST) begin
                  query_in = 1'b1;
               end else if (uri_byte == uripsp_pkg::CH_SLASH ||
                            uri_byte == uripsp_pkg::CH_BSLASH) begin
                  // back end decides: close outside brackets (only after a name char), value char inside
                  op.code = uripsp_pkg::OP_SEP;
               end else if (uri_byte == uripsp_pkg::CH_PERCENT) begin
                  if (last_byte) begin
                     op.code = uripsp_pkg::OP_CHAR;
                  end else begin
                     esc_in = uripsp_pkg::ESC_FIRST;
                  end
               end else if (uri_byte == uripsp_pkg::CH_PLUS) begin
                  op.code = uripsp_pkg::OP_CHAR;
                  op.ch   = uripsp_pkg::CH_SPACE;
               end else begin
                  op.code = uripsp_pkg::OP_CHAR;
               end
            end
         endcase
      end
      if (last_byte) begin
         esc_in   = uripsp_pkg::ESC_IDLE;
         hi_in    = 4'h0;
         query_in = 1'b0;
      end
   end

   assign op_push = accept && (op.code != uripsp_pkg::OP_NONE || last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= uripsp_pkg::ESC_IDLE;
         hi_ff    <= 4'h0;
         query_ff <= 1'b0;
      end else if (accept) begin
         esc_ff   <= esc_in;
         hi_ff    <= hi_in;
         query_ff <= query_in;
      end
   end

   a_query_no_escape: assert property (@(posedge clock) disable iff (reset)
      query_ff |-> esc_ff == uripsp_pkg::ESC_IDLE)
      else $error("escape pending inside query part");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> esc_ff == uripsp_pkg::ESC_IDLE && !query_ff)
      else $error("front state not cleared after last byte");

endmodule

/* src/uripsp_op_fifo.sv */
module uripsp_op_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  uripsp_pkg::op_type   wdata,
   output logic                 full,
   input  logic                 pop_i,
   output logic                 valid,
   output uripsp_pkg::op_type   rdata
);

   uripsp_pkg::op_type                    entry_ff [uripsp_pkg::OPQ_DEPTH];
   logic [uripsp_pkg::OPQ_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [uripsp_pkg::OPQ_CNT_BITS-1:0]   count_ff, count_in;
   logic                                  do_push, do_pop;

   assign full    = count_ff == uripsp_pkg::OPQ_CNT_BITS'(uripsp_pkg::OPQ_DEPTH);
   assign valid   = count_ff != '0;
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push_i && !full;
   assign do_pop  = pop_i && valid;

   always_comb begin
      count_in = count_ff + uripsp_pkg::OPQ_CNT_BITS'(do_push)
                          - uripsp_pkg::OPQ_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push_i)
      else $error("op queue pushed while full");

endmodule

/* src/uripsp_back.sv */
module uripsp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   input  uripsp_pkg::op_type       op,
   input  logic                     room2,
   output logic                     op_pop,
   output uripsp_pkg::rsp_wr_type   wr
);

   logic [uripsp_pkg::DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                              ne_ff, ne_in;
   logic                              take;

   assign take   = op_valid && room2;
   assign op_pop = take;

   always_comb begin
      logic                              do_char;
      logic                              is_open, is_close;
      logic [uripsp_pkg::DEPTH_BITS-1:0] nd;
      logic [7:0]                        ce;
      logic                              has_a;
      uripsp_pkg::rsp_type               res_a, res_end;

      depth_in = depth_ff;
      ne_in    = ne_ff;
      do_char  = 1'b0;
      has_a    = 1'b0;
      res_a    = '0;
      res_end  = '0;
      nd       = depth_ff;
      ce       = op.ch;
      is_open  = op.ch == uripsp_pkg::CH_LBRACK || op.ch == uripsp_pkg::CH_LPAREN;
      is_close = op.ch == uripsp_pkg::CH_RBRACK || op.ch == uripsp_pkg::CH_RPAREN;
      wr       = '0;

      unique case (op.code)
         uripsp_pkg::OP_CHAR: do_char = 1'b1;
         uripsp_pkg::OP_SEP: begin
            if (depth_ff == '0) begin
               if (ne_ff) begin
                  has_a      = 1'b1;
                  res_a.kind = uripsp_pkg::KIND_CLOSE;
                  ne_in      = 1'b0;
               end
            end else begin
               do_char = 1'b1;
            end
         end
         default: ;
      endcase

      if (do_char) begin
         if (is_open) begin
            if (depth_ff == '0) begin
               if (ne_ff) begin
                  nd = uripsp_pkg::DEPTH_BITS'(1);
                  ce = 8'h00;
               end
            end else if (depth_ff < uripsp_pkg::DEPTH_MAX) begin
               nd = depth_ff + 1'b1;
            end
         end else if (is_close) begin
            if (depth_ff != '0) begin
               nd = depth_ff - 1'b1;
               if (nd == '0) ce = 8'h00;
            end
         end
         depth_in = nd;
         // decoded zero bytes, the bracket opening a value after a name and the bracket closing it vanish here
         if (ce != 8'h00) begin
            has_a    = 1'b1;
            res_a.ch = ce;
            if (nd != '0) begin
               res_a.kind = uripsp_pkg::KIND_VALUE;
            end else begin
               res_a.kind = uripsp_pkg::KIND_NAME;
               ne_in      = 1'b1;
            end
         end
      end

      if (op.last) begin
         res_end.kind = ne_in ? uripsp_pkg::KIND_CLOSE : uripsp_pkg::KIND_END;
         res_end.eou  = 1'b1;
         depth_in     = '0;
         ne_in        = 1'b0;
      end

      if (take) begin
         if (has_a) begin
            wr.r0 = res_a;
            wr.r1 = res_end;
            wr.n  = op.last ? 2'd2 : 2'd1;
         end else begin
            wr.r0 = res_end;
            wr.n  = op.last ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         ne_ff    <= 1'b0;
      end else if (take) begin
         depth_ff <= depth_in;
         ne_ff    <= ne_in;
      end
   end

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      take && op.last |=> depth_ff == '0 && !ne_ff)
      else $error("segment state not cleared after end of URI");

   a_last_always_writes: assert property (@(posedge clock) disable iff (reset)
      take && op.last |-> wr.n != 2'd0)
      else $error("end of URI produced no result");

endmodule

/* src/uripsp_rsp_fifo.sv */
module uripsp_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  uripsp_pkg::rsp_wr_type   wr,
   output logic                     room2,
   input  logic                     pop_i,
   output logic                     empty,
   output uripsp_pkg::rsp_type      rdata
);

   uripsp_pkg::rsp_type                   entry_ff [uripsp_pkg::RSPQ_DEPTH];
   logic [uripsp_pkg::RSPQ_PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff, wr_ptr_nx;
   logic [uripsp_pkg::RSPQ_CNT_BITS-1:0]  count_ff, count_in;
   logic                                  do_pop;

   assign room2     = count_ff <= uripsp_pkg::RSPQ_CNT_BITS'(uripsp_pkg::RSPQ_DEPTH - 2);
   assign empty     = count_ff == '0;
   assign rdata     = entry_ff[rd_ptr_ff];
   assign do_pop    = pop_i && !empty;
   assign wr_ptr_nx = wr_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff + uripsp_pkg::RSPQ_CNT_BITS'(wr.n)
                          - uripsp_pkg::RSPQ_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (wr.n != 2'd0) entry_ff[wr_ptr_ff] <= wr.r0;
      if (wr.n == 2'd2) entry_ff[wr_ptr_nx] <= wr.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + uripsp_pkg::RSPQ_PTR_BITS'(wr.n);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_write_fits: assert property (@(posedge clock) disable iff (reset)
      wr.n != 2'd0 |-> room2)
      else $error("result queue written without room");

endmodule
